// File: design/wavetable_oscillator_top_assert.svh
// ----------------------------------------------------------------------------
// wavetable oscillator assertion macros
// simple implication checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_TOP_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WTO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wavetable oscillator: same-cycle check failed");

// next-cycle implication
`define WTO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wavetable oscillator: next-cycle check failed");

`else

`define WTO_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WTO_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/wto_pkg.sv
// ----------------------------------------------------------------------------
// wto_pkg
// sizes, register indexes, note increment table and shared types
// ----------------------------------------------------------------------------
package wto_pkg;

	localparam int unsigned TableDepth    = 16384;
	localparam int unsigned FrameSize     = 2048;
	localparam int unsigned PhaseFracBits = 16;

	localparam int unsigned AddrWidth   = $clog2(TableDepth);
	localparam int unsigned FrameBits   = $clog2(FrameSize);
	localparam int unsigned PhaseWidth  = FrameBits + PhaseFracBits;
	localparam int unsigned IncWidth    = 26;
	localparam int unsigned SampleWidth = 16;
	localparam int unsigned NoteWidth   = 7;
	localparam int unsigned PosWidth    = 17;
	localparam int unsigned CfgWidth    = 17;
	localparam int unsigned NoteCount   = 128;

	localparam int unsigned FrameCount = TableDepth / FrameSize;
	localparam int unsigned FrameMul   = (FrameCount == 0) ? 0 : FrameCount - 1;
	localparam int unsigned MulWidth   = PosWidth + $clog2(FrameMul + 2);

	// register indexes of the configuration port
	localparam logic RegMidiNote = 1'b0;
	localparam logic RegTablePos = 1'b1;

	localparam logic [NoteWidth-1:0] MidiNoteReset = NoteWidth'(69);
	localparam logic [PosWidth-1:0]  PosOne        = PosWidth'(65536);

	localparam longint unsigned IncMax = (64'd1 << IncWidth) - 64'd1;
	// semitone ratio of note a (index 9) times the sample rate
	localparam longint unsigned IncDen = 64'd28215802 * 64'd44100;

	typedef logic [NoteCount-1:0][IncWidth-1:0] inc_table_t;

	// semitone ratios 2^(k/12) in q24
	function automatic longint unsigned semi_ratio(input int unsigned k);
		case (k)
			0:       return 64'd16777216;
			1:       return 64'd17774841;
			2:       return 64'd18831788;
			3:       return 64'd19951585;
			4:       return 64'd21137968;
			5:       return 64'd22394897;
			6:       return 64'd23726566;
			7:       return 64'd25137421;
			8:       return 64'd26632170;
			9:       return 64'd28215802;
			10:      return 64'd29893600;
			default: return 64'd31671666;
		endcase
	endfunction

	// built at elaboration, one entry per note
	function automatic inc_table_t build_inc_table();
		inc_table_t      tab;
		longint unsigned num;
		longint unsigned q;
		int              s;
		int unsigned     oct;
		int unsigned     k;
		for (int unsigned n = 0; n < NoteCount; n++) begin
			oct = n / 12;
			k   = n % 12;
			num = 64'd440 * semi_ratio(k) * longint'(FrameSize);
			q   = (num << 17) / IncDen;
			s   = int'(PhaseFracBits) + int'(oct) - 22;
			if (s >= 0) begin
				if (s >= 30 || q > (IncMax >> s)) begin
					q = IncMax;
				end else begin
					q = q << s;
				end
			end else begin
				q = (-s >= 64) ? 64'd0 : (q >> (-s));
			end
			if (q > IncMax) begin
				q = IncMax;
			end
			tab[n] = q[IncWidth-1:0];
		end
		return tab;
	endfunction

	localparam inc_table_t IncTable = build_inc_table();

	// one table access travelling from the first stage to the memory
	typedef struct packed {
		logic                   rd;    // tick read, otherwise sample write
		logic [AddrWidth-1:0]   addr;
		logic [SampleWidth-1:0] data;
	} wto_req_t;

endpackage

// File: design/wto_phase.sv
// ----------------------------------------------------------------------------
// wto_phase
// config registers, phase accumulator and read index for each tick
// ----------------------------------------------------------------------------
module wto_phase (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [wto_pkg::CfgWidth-1:0]  cfg_data,
	input  logic                          tick,
	output logic [wto_pkg::AddrWidth-1:0] rd_index,
	output logic [wto_pkg::AddrWidth-1:0] offset
);

	localparam int unsigned PW = wto_pkg::PhaseWidth;
	localparam int unsigned AW = wto_pkg::AddrWidth;
	localparam int unsigned MW = wto_pkg::MulWidth;

	localparam logic [PW:0] WrapLimit = (PW+1)'(wto_pkg::FrameSize) << wto_pkg::PhaseFracBits;

	logic [PW-1:0]                  phase_q;
	logic [wto_pkg::IncWidth-1:0]   increment_q;
	logic [AW-1:0]                  offset_q;
	logic [PW:0]                    phase_sum;
	logic [PW-1:0]                  phase_next;
	logic [wto_pkg::PosWidth-1:0]   pos_sat;
	logic [MW-1:0]                  pos_prod;
	logic [AW-1:0]                  offset_new;

	// frame start from table position, saturated at one
	always_comb begin
		pos_sat = (cfg_data > wto_pkg::PosOne) ? wto_pkg::PosOne : cfg_data;
		pos_prod = MW'(pos_sat) * MW'(wto_pkg::FrameMul);
		offset_new = AW'(pos_prod >> 16) << wto_pkg::FrameBits;
	end

	always_comb begin
		phase_sum = (PW+1)'(phase_q) + (PW+1)'(increment_q);
		phase_next = (phase_sum >= WrapLimit) ? '0 : phase_sum[PW-1:0];
		rd_index = AW'(phase_next[PW-1:wto_pkg::PhaseFracBits]) + offset_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			increment_q <= wto_pkg::IncTable[wto_pkg::MidiNoteReset];
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wto_pkg::RegMidiNote: begin
					increment_q <= wto_pkg::IncTable[cfg_data[wto_pkg::NoteWidth-1:0]];
				end
				wto_pkg::RegTablePos: begin
					offset_q <= offset_new;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (tick) begin
			phase_q <= phase_next;
		end
	end

	assign offset = offset_q;

endmodule

// File: design/wto_table.sv
// ----------------------------------------------------------------------------
// wto_table
// single-port wavetable memory, one write or one registered read per enabled cycle
// ----------------------------------------------------------------------------
module wto_table (
	input  logic                            clk,
	input  logic                            en,
	input  wto_pkg::wto_req_t               req_s1,
	output logic [wto_pkg::SampleWidth-1:0] sample_s2
);

	logic [wto_pkg::SampleWidth-1:0] mem [wto_pkg::TableDepth];

	always_ff @(posedge clk) begin
		if (en) begin
			if (req_s1.rd) begin
				sample_s2 <= mem[req_s1.addr];
			end else begin
				mem[req_s1.addr] <= req_s1.data;
			end
		end
	end

endmodule

// File: design/wavetable_oscillator_top.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_top
// wavetable oscillator: sample loads into a table, ticks read it by phase
// ----------------------------------------------------------------------------
// a tick request passes the first-stage register, then the registered table read
// throughput: one request per cycle while the output is not stalled, set by the single table port
// load requests give no result and take one table write slot each
// reset clears phase, frame offset and pipeline valids; note resets to 69
// table contents are undefined after reset until loaded
module wavetable_oscillator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [wto_pkg::CfgWidth-1:0] cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,  // load_address, load_data
	input  logic                         s_tuser,  // action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata   // sample, frame_offset
);

	localparam int unsigned AW = wto_pkg::AddrWidth;
	localparam int unsigned SW = wto_pkg::SampleWidth;

	logic              in_take;
	logic              tick;
	logic              ready_s2;
	logic              adv_s1;
	logic [AW-1:0]     rd_index;
	logic [AW-1:0]     offset;
	logic              v_s1;
	wto_pkg::wto_req_t req_s1;
	logic [AW-1:0]     offset_s1;
	logic              v_s2;
	logic [AW-1:0]     offset_s2;
	logic [SW-1:0]     sample_s2;

	assign ready_s2 = !v_s2 || m_tready;
	assign adv_s1 = v_s1 && ready_s2;
	assign s_tready = !v_s1 || ready_s2;
	assign in_take = s_tvalid && s_tready;
	assign tick = in_take && s_tuser;

	wto_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick),
		.rd_index  (rd_index),
		.offset    (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// ticks carry the computed index, loads their own address
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.rd <= s_tuser;
			req_s1.addr <= s_tuser ? rd_index : s_tdata[AW-1:0];
			req_s1.data <= s_tdata[AW +: SW];
			offset_s1 <= offset;
		end
	end

	wto_table u_table (
		.clk       (clk),
		.en        (adv_s1),
		.req_s1    (req_s1),
		.sample_s2 (sample_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1 && req_s1.rd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_s1.rd) begin
			offset_s2 <= offset_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = {2'b00, offset_s2, sample_s2};

`include "wavetable_oscillator_top_assert.svh"

	// a load never turns into a result
	`WTO_ASSERT_NEXT(a_load_no_result, clk, arst_n, adv_s1 && !req_s1.rd, !m_tvalid)
	// a tick leaving the first stage always shows up at the output
	`WTO_ASSERT_NEXT(a_tick_gives_result, clk, arst_n, adv_s1 && req_s1.rd, m_tvalid)
	// read index stays inside the selected frame
	`WTO_ASSERT_NOW(a_index_in_frame, clk, arst_n, v_s1 && req_s1.rd,
		(req_s1.addr >= offset_s1) && ((req_s1.addr - offset_s1) < AW'(wto_pkg::FrameSize)))

endmodule

// File: bench/wavetable_oscillator_top_tb.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_top_tb
// Self-checking bench for the wavetable oscillator. Load and tick requests go
// in over the slave stream, with random gaps. Results come back over the
// master stream, with random stalls. An in-bench phase accumulator and table
// copy predict each tick's sample and frame offset. The note and the table
// position are stepped through their extremes between drained phases. Ticks
// only read table entries that have already been loaded.
// ----------------------------------------------------------------------------
module wavetable_oscillator_top_tb;

	localparam int unsigned     OSC_LATENCY = 2;
	localparam int              ITEM_TARGET = 1650;
	localparam longint unsigned CYCLE_LIMIT = 1000000;
	localparam longint unsigned STEP_MAX    = (64'd1 << wto_pkg::IncWidth) - 64'd1;
	localparam longint unsigned SEMITONE_Q24 [12] = '{
		64'd16777216, 64'd17774841, 64'd18831788, 64'd19951585,
		64'd21137968, 64'd22394897, 64'd23726566, 64'd25137421,
		64'd26632170, 64'd28215802, 64'd29893600, 64'd31671666
	};

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TICK = 1'b1
	} osc_action_e;

	typedef struct packed {
		osc_action_e action;
		logic [13:0] addr;
		logic [15:0] data;
	} osc_request_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [13:0] frame_offset;
	} osc_result_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic                         cfg_index = 1'b0;
	logic [wto_pkg::CfgWidth-1:0] cfg_data  = '0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [31:0]                  s_tdata   = '0;  // load_address, load_data
	logic                         s_tuser   = 1'b0; // action
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [31:0]                  m_tdata;          // sample, frame_offset

	// shared oscillator settings, only changed while the block is idle
	longint unsigned phase_step;
	longint unsigned frame_base;

	// prediction side
	logic [15:0]     table_copy [0:wto_pkg::TableDepth-1];
	longint unsigned osc_phase;
	osc_result_t     expected_samples [$];

	// stimulus side
	bit              loaded [0:wto_pkg::TableDepth-1];
	longint unsigned plan_phase;
	osc_request_t    pending_requests [$];

	int              requests_planned = 0;
	int              requests_taken   = 0;
	int              loads_taken      = 0;
	int              results_seen     = 0;
	int              cfg_writes       = 0;
	int              errors           = 0;
	bit              idle_on          = 1'b1;
	int              gap_left         = 0;
	int              stall_left       = 0;
	longint unsigned cycle_count      = 0;

	wavetable_oscillator_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// phase increment for a note, q16, truncated at each step
	function automatic longint unsigned note_phase_step(input int unsigned note);
		longint unsigned q;
		int              shift;
		q = ((64'd440 * SEMITONE_Q24[note % 12] * longint'(wto_pkg::FrameSize)) << 17)
			/ (SEMITONE_Q24[9] * 64'd44100);
		shift = int'(wto_pkg::PhaseFracBits) + int'(note / 12) - 22;
		if (shift >= 0) begin
			q = (shift >= 30 || q > (STEP_MAX >> shift)) ? STEP_MAX : (q << shift);
		end else begin
			q = q >> (-shift);
		end
		return (q > STEP_MAX) ? STEP_MAX : q;
	endfunction

	function automatic longint unsigned frame_start(input longint unsigned pos);
		longint unsigned frames = wto_pkg::TableDepth / wto_pkg::FrameSize;
		if (pos > wto_pkg::PosOne) begin
			pos = wto_pkg::PosOne;
		end
		if (frames == 0) begin
			return 0;
		end
		return ((pos * (frames - 1)) >> 16) * wto_pkg::FrameSize;
	endfunction

	// reaching the frame size drops the phase to zero
	function automatic longint unsigned advance_phase(input longint unsigned p);
		longint unsigned sum = p + phase_step;
		return (sum >= (longint'(wto_pkg::FrameSize) << wto_pkg::PhaseFracBits)) ? 0 : sum;
	endfunction

	function automatic void absorb_request(input logic action, input logic [13:0] addr,
		input logic [15:0] data);
		osc_result_t     res;
		longint unsigned idx;
		if (action == ACT_LOAD) begin
			if (addr < wto_pkg::TableDepth) begin
				table_copy[addr] = data;
			end
			loads_taken++;
			return;
		end
		osc_phase = advance_phase(osc_phase);
		idx = (osc_phase >> wto_pkg::PhaseFracBits) + frame_base;
		res.sample       = (idx < wto_pkg::TableDepth) ? table_copy[idx] : '0;
		res.frame_offset = frame_base[13:0];
		expected_samples.push_back(res);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [15:0] random_sample();
		int r;
		r = $urandom_range(0, 39);
		case (r)
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void plan_load(input logic [13:0] addr, input logic [15:0] data);
		osc_request_t req;
		req.action = ACT_LOAD;
		req.addr   = addr;
		req.data   = data;
		pending_requests.push_back(req);
		loaded[addr] = 1'b1;
		requests_planned++;
	endfunction

	// the entry a tick will read is loaded first if it never was
	function automatic void plan_tick();
		osc_request_t    req;
		longint unsigned idx;
		plan_phase = advance_phase(plan_phase);
		idx = (plan_phase >> wto_pkg::PhaseFracBits) + frame_base;
		if (idx < wto_pkg::TableDepth && !loaded[idx]) begin
			plan_load(idx[13:0], random_sample());
		end
		req.action = ACT_TICK;
		req.addr   = 14'($urandom);
		req.data   = 16'($urandom);
		pending_requests.push_back(req);
		requests_planned++;
	endfunction

	task automatic write_reg(input logic index, input logic [wto_pkg::CfgWidth-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == wto_pkg::RegMidiNote) begin
			phase_step = note_phase_step(value[6:0]);
		end else begin
			frame_base = frame_start(value);
		end
		cfg_writes++;
	endtask

	// upper data bits on a note write carry junk that the block should drop
	task automatic set_config(input int unsigned note, input logic [16:0] pos);
		write_reg(wto_pkg::RegMidiNote, {10'($urandom), note[6:0]});
		write_reg(wto_pkg::RegTablePos, pos);
	endtask

	task automatic settle();
		while (requests_taken != requests_planned || expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (OSC_LATENCY + 3) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : request_drive
		osc_request_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser  <= ACT_LOAD;
			s_tdata  <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_request(s_tuser, s_tdata[13:0], s_tdata[29:14]);
				requests_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					req = pending_requests.pop_front();
					s_tuser  <= req.action;
					s_tdata  <= {2'b00, req.data, req.addr};
					s_tvalid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_check
		osc_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_samples.size() == 0) begin
					$error("result with no tick pending: sample %0d frame_offset %0d",
						$signed(m_tdata[15:0]), m_tdata[29:16]);
					errors++;
				end else begin
					want = expected_samples.pop_front();
					if (m_tdata[15:0] !== want.sample) begin
						$error("sample: expected %0d, got %0d",
							$signed(want.sample), $signed(m_tdata[15:0]));
						errors++;
					end
					if (m_tdata[29:16] !== want.frame_offset) begin
						$error("frame_offset: expected %0d, got %0d",
							want.frame_offset, m_tdata[29:16]);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int          r;
		int          phase_no;
		int unsigned note;
		logic [16:0] pos;
		phase_step = note_phase_step(wto_pkg::MidiNoteReset);
		frame_base = frame_start(0);
		osc_phase  = 0;
		plan_phase = 0;
		phase_no   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, extreme addresses and sample values
		plan_load(14'h0000, 16'h8000);
		plan_load(14'h3FFF, 16'h7FFF);
		plan_load(14'h2AAA, 16'h5555);
		plan_load(14'h1555, 16'hAAAA);
		repeat (4) plan_tick();
		// top note wraps the phase often, position above one clamps to the last frame
		settle();
		set_config(127, 17'h1FFFF);
		repeat (4) plan_tick();
		// bottom note, position exactly one
		settle();
		set_config(0, 17'd65536);
		repeat (2) plan_tick();

		while (requests_planned < ITEM_TARGET) begin
			settle();
			case (phase_no)
				0: begin
					note = 0;
					pos  = 17'd0;
				end
				1: begin
					note = 127;
					pos  = 17'd65536;
				end
				2: begin
					note = wto_pkg::MidiNoteReset;
					pos  = 17'($urandom_range(65537, 131071));
				end
				default: begin
					note = $urandom_range(0, 127);
					pos  = ($urandom_range(0, 6) == 0) ? 17'($urandom_range(65537, 131071))
						: 17'($urandom_range(0, 65536));
				end
			endcase
			set_config(note, pos);
			idle_on = (phase_no % 4 != 1);
			for (int i = 0; i < 150; i++) begin
				// sender holds off until the result stream has drained
				if (phase_no == 3 && i == 75) begin
					settle();
				end
				r = $urandom_range(0, 99);
				if (r < 68) begin
					plan_tick();
				end else if (r < 78) begin
					// rewrite entries just ahead of the read pointer
					plan_load(14'((plan_phase >> wto_pkg::PhaseFracBits) + frame_base
						+ $urandom_range(0, 40)), random_sample());
				end else begin
					plan_load(14'($urandom), random_sample());
				end
			end
			phase_no++;
		end
		settle();

		$display("covered %0d requests: %0d loads and %0d ticks checked",
			requests_taken, loads_taken, results_seen);
		$display("over %0d register writes across %0d random setting phases",
			cfg_writes, phase_no);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
